// ===== rtl/core/rrvca_pkg.sv =====
// shared types and constants for the round-robin vc allocator
// no dependencies; imported by rrvca_rr_arb and round_robin_vc_allocator_top
`default_nettype none

package rrvca_pkg;

  localparam int NUM_PORTS_DEF = 5;
  localparam int NUM_VCS_DEF   = 4;

  // fixed field widths of the channel words
  localparam int OP_W    = 2;
  localparam int PORT_FW = 3;
  localparam int VC_FW   = 2;
  localparam int CRED_W  = 20;

  localparam logic [OP_W-1:0] OP_REQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_REL  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  typedef struct packed {
    logic               vld;
    logic [PORT_FW-1:0] in_port;
    logic [VC_FW-1:0]   in_vc;
  } vca_gnt_t;

  typedef struct packed {
    logic               granted;
    logic [PORT_FW-1:0] oport;
    logic [VC_FW-1:0]   out_vc;
    logic [PORT_FW-1:0] in_port;
    logic [VC_FW-1:0]   in_vc;
    logic               last;
  } vca_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/round_robin_vc_allocator_top.sv =====
// round-robin virtual-channel allocator, top level
// depends on rrvca_pkg and rrvca_rr_arb
//
// input channel (in_valid/in_ready) takes one word per accepted item:
//   request - records an input vc's wish for an output port and vc; an
//             existing pending request for that port is kept
//   release - frees an output vc
//   tick    - scans every output vc in port-then-vc order and grants the
//             free ones with full credits, round robin over all input vcs
// requests and releases finish in the accept cycle and give no word.
// during a tick, unless the scan is stalled, one output vc per cycle is read
// from the target-vc memory and the search-start memory and is arbitrated
// in the cycle after its read. in_ready is low during the scan. each grant
// gives one word on the out_ channel, the final one with out_last set; a
// tick without grants gives one empty word.
// one grant is held back until the next is known, so the scan pauses only
// when a second grant finds the output register still full.
// after reset no requests are pending, all output vcs are free and all
// search pointers are zero; the block is ready in the first cycle.
`default_nettype none

module round_robin_vc_allocator_top
  import rrvca_pkg::*;
#(
  parameter int NUM_PORTS = NUM_PORTS_DEF,
  parameter int NUM_VCS   = NUM_VCS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [OP_W-1:0]    in_op,
  input  wire logic [PORT_FW-1:0] in_out_port,
  input  wire logic [VC_FW-1:0]   in_out_vc,
  input  wire logic [PORT_FW-1:0] in_in_port,
  input  wire logic [VC_FW-1:0]   in_in_vc,
  input  wire logic [CRED_W-1:0]  in_credits_full,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_granted,
  output logic [PORT_FW-1:0]      out_grant_out_port,
  output logic [VC_FW-1:0]        out_grant_out_vc,
  output logic [PORT_FW-1:0]      out_grant_in_port,
  output logic [VC_FW-1:0]        out_grant_in_vc,
  output logic                    out_last
);

  localparam int TOT    = NUM_PORTS * NUM_VCS;
  localparam int TOT_W  = (TOT > 1) ? $clog2(TOT) : 1;
  localparam int PORT_W = $clog2(NUM_PORTS);
  localparam int VC_W   = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;

  typedef enum logic [0:0] {ST_IDLE, ST_SCAN} state_t;

  state_t            state_r;
  logic              out_valid_r;
  vca_word_t         out_word_r;
  logic              hold_vld_r;
  vca_word_t         hold_word_r;
  logic              s1_vld_r;
  logic [PORT_W-1:0] s1_port_r;
  logic [VC_W-1:0]   s1_vc_r;
  logic [TOT_W-1:0]  s1_oidx_r;
  logic [PORT_W-1:0] ptr_port_r;
  logic [VC_W-1:0]   ptr_vc_r;
  logic [TOT_W-1:0]  ptr_oidx_r;
  logic              rd_done_r;
  logic [TOT-1:0]    busy_r;
  logic [TOT-1:0]    cred_r;
  logic [TOT-1:0]    start_vld_r;
  logic [TOT-1:0]    pend_r [NUM_PORTS];

  // memories
  logic [TOT*VC_W-1:0] tgt_mem [NUM_PORTS];
  logic [TOT*VC_W-1:0] tgt_rd_r;
  logic [TOT_W-1:0]    start_mem [TOT];
  logic [TOT_W-1:0]    start_rd_r;

  // input decode
  logic [3:0]        ext_oport;
  logic [3:0]        ext_ovc;
  logic [3:0]        ext_iport;
  logic [3:0]        ext_ivc;
  logic [PORT_W-1:0] op_idx;
  logic [VC_W-1:0]   ov_idx;
  logic [PORT_W-1:0] ip_idx;
  logic [VC_W-1:0]   iv_idx;
  logic              out_ok;
  logic              in_ok;
  logic [TOT_W-1:0]  req_slot;
  logic [TOT_W-1:0]  rel_oidx;
  logic              acc;
  logic              is_tick;
  logic              req_wr;

  logic [CRED_W+TOT-1:0] cred_ext;

  // scan pointer
  logic [PORT_W-1:0] cur_port;
  logic [VC_W-1:0]   cur_vc;
  logic [TOT_W-1:0]  cur_oidx;
  logic [PORT_W-1:0] inc_port;
  logic [VC_W-1:0]   inc_vc;
  logic              cur_last;

  // evaluation stage
  logic [TOT-1:0]   match;
  logic [TOT-1:0]   arb_req;
  logic [TOT_W-1:0] s1_start;
  vca_gnt_t         gnt;
  logic [TOT_W-1:0] gnt_idx;
  logic [TOT_W-1:0] nxt_start;
  logic             out_free;
  logic             stall;
  logic             adv;
  logic             grant_take;
  logic             rd_en;
  logic             out_load;
  vca_word_t        new_word;
  vca_word_t        fin_word;

  assign ext_oport = 4'(in_out_port);
  assign ext_ovc   = 4'(in_out_vc);
  assign ext_iport = 4'(in_in_port);
  assign ext_ivc   = 4'(in_in_vc);
  assign op_idx    = ext_oport[PORT_W-1:0];
  assign ov_idx    = ext_ovc[VC_W-1:0];
  assign ip_idx    = ext_iport[PORT_W-1:0];
  assign iv_idx    = ext_ivc[VC_W-1:0];
  assign out_ok    = (int'(in_out_port) < NUM_PORTS) && (int'(in_out_vc) < NUM_VCS);
  assign in_ok     = (int'(in_in_port) < NUM_PORTS) && (int'(in_in_vc) < NUM_VCS);
  assign req_slot  = TOT_W'(int'(ip_idx) * NUM_VCS + int'(iv_idx));
  assign rel_oidx  = TOT_W'(int'(op_idx) * NUM_VCS + int'(ov_idx));

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign is_tick  = acc && (in_op == OP_TICK);
  assign req_wr   = acc && (in_op == OP_REQ) && out_ok && in_ok && !pend_r[op_idx][req_slot];
  assign cred_ext = {TOT'(0), in_credits_full};

  // next output vc to read; restarts at zero on a tick
  assign cur_port = (state_r == ST_IDLE) ? '0 : ptr_port_r;
  assign cur_vc   = (state_r == ST_IDLE) ? '0 : ptr_vc_r;
  assign cur_oidx = (state_r == ST_IDLE) ? '0 : ptr_oidx_r;
  assign cur_last = (cur_oidx == TOT_W'(TOT - 1));
  assign inc_vc   = (int'(cur_vc) == NUM_VCS - 1) ? '0 : cur_vc + 1'b1;
  assign inc_port = (int'(cur_vc) == NUM_VCS - 1) ? cur_port + 1'b1 : cur_port;

  always_comb begin
    for (int j = 0; j < TOT; j++) begin
      match[j] = pend_r[s1_port_r][j] && (tgt_rd_r[j*VC_W +: VC_W] == s1_vc_r);
    end
  end

  assign arb_req  = (!busy_r[s1_oidx_r] && cred_r[s1_oidx_r]) ? match : '0;
  assign s1_start = start_vld_r[s1_oidx_r] ? start_rd_r : '0;

  rrvca_rr_arb #(
    .NUM_PORTS (NUM_PORTS),
    .NUM_VCS   (NUM_VCS)
  ) u_arb (
    .req     (arb_req),
    .start   (s1_start),
    .gnt     (gnt),
    .gnt_idx (gnt_idx)
  );

  assign nxt_start  = (gnt_idx == TOT_W'(TOT - 1)) ? '0 : gnt_idx + 1'b1;
  assign out_free   = !out_valid_r || out_ready;
  assign stall      = gnt.vld && hold_vld_r && !out_free;
  assign adv        = !stall;
  assign grant_take = (state_r == ST_SCAN) && s1_vld_r && adv && gnt.vld;
  assign rd_en      = is_tick || ((state_r == ST_SCAN) && s1_vld_r && adv && !rd_done_r);
  assign out_load   = (state_r == ST_SCAN) &&
                      (s1_vld_r ? (adv && gnt.vld && hold_vld_r) : out_free);

  always_comb begin
    new_word          = '0;
    new_word.granted  = 1'b1;
    new_word.oport    = PORT_FW'(s1_port_r);
    new_word.out_vc   = VC_FW'(s1_vc_r);
    new_word.in_port  = gnt.in_port;
    new_word.in_vc    = gnt.in_vc;
    fin_word          = hold_vld_r ? hold_word_r : '0;
    fin_word.last     = 1'b1;
  end

  // target-vc memory, one row per output port, written per entry
  always_ff @(posedge clk) begin
    if (req_wr) begin
      tgt_mem[op_idx][req_slot*VC_W +: VC_W] <= ov_idx;
    end
    if (rd_en) begin
      tgt_rd_r <= tgt_mem[cur_port];
    end
  end

  // search-start memory, one entry per output vc
  always_ff @(posedge clk) begin
    if (grant_take) begin
      start_mem[s1_oidx_r] <= nxt_start;
    end
    if (rd_en) begin
      start_rd_r <= start_mem[cur_oidx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hold_vld_r  <= 1'b0;
      s1_vld_r    <= 1'b0;
      rd_done_r   <= 1'b0;
      busy_r      <= '0;
      start_vld_r <= '0;
      for (int p = 0; p < NUM_PORTS; p++) begin
        pend_r[p] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      // pipeline advance shared by tick start and scan
      if (rd_en) begin
        s1_vld_r   <= 1'b1;
        s1_port_r  <= cur_port;
        s1_vc_r    <= cur_vc;
        s1_oidx_r  <= cur_oidx;
        ptr_port_r <= inc_port;
        ptr_vc_r   <= inc_vc;
        ptr_oidx_r <= cur_oidx + 1'b1;
        rd_done_r  <= cur_last;
      end
      case (state_r)
        ST_IDLE: begin
          if (acc) begin
            case (in_op)
              OP_REQ: begin
                if (req_wr) begin
                  pend_r[op_idx][req_slot] <= 1'b1;
                end
              end
              OP_REL: begin
                if (out_ok) begin
                  busy_r[rel_oidx] <= 1'b0;
                end
              end
              OP_TICK: begin
                cred_r     <= cred_ext[TOT-1:0];
                hold_vld_r <= 1'b0;
                state_r    <= ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (s1_vld_r) begin
            if (adv) begin
              if (!rd_en) begin
                s1_vld_r <= 1'b0;
              end
              if (gnt.vld) begin
                busy_r[s1_oidx_r]        <= 1'b1;
                pend_r[s1_port_r][gnt_idx] <= 1'b0;
                start_vld_r[s1_oidx_r]   <= 1'b1;
                hold_word_r              <= new_word;
                hold_vld_r               <= 1'b1;
                if (hold_vld_r) begin
                  out_word_r  <= hold_word_r;
                end
              end
            end
          end else if (out_free) begin
            // scan done: flush the held grant or an empty word
            out_word_r  <= fin_word;
            hold_vld_r  <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted        = out_word_r.granted;
  assign out_grant_out_port = out_word_r.oport;
  assign out_grant_out_vc   = out_word_r.out_vc;
  assign out_grant_in_port  = out_word_r.in_port;
  assign out_grant_in_vc    = out_word_r.in_vc;
  assign out_last           = out_word_r.last;

  // a granted output vc is marked busy right after the grant
  a_grant_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    grant_take |=> busy_r[$past(s1_oidx_r)])
    else $error("granted output vc not marked busy");

  // the arbiter only picks an input vc that asked for this output vc
  a_grant_is_request: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && s1_vld_r && gnt.vld) |-> arb_req[gnt_idx])
    else $error("grant without matching request");

  // every tick ends with a final word in the output register
  a_tick_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(state_r) == ST_SCAN && state_r == ST_IDLE)
      |-> (out_valid_r && out_word_r.last))
    else $error("tick finished without a last word");

  // no output word may be lost while the receiver stalls
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_word_r)))
    else $error("pending output word overwritten");

  // evaluation stage only holds a real output port
  a_s1_port_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> (int'(s1_port_r) < NUM_PORTS))
    else $error("scan port out of range");

endmodule

`default_nettype wire

// ===== rtl/core/rrvca_rr_arb.sv =====
// round-robin arbiter over all input vcs, first request at or after start, else the lowest
// depends on rrvca_pkg
`default_nettype none

module rrvca_rr_arb
  import rrvca_pkg::*;
#(
  parameter int NUM_PORTS = NUM_PORTS_DEF,
  parameter int NUM_VCS   = NUM_VCS_DEF,
  localparam int TOT   = NUM_PORTS * NUM_VCS,
  localparam int TOT_W = (TOT > 1) ? $clog2(TOT) : 1
) (
  input  wire logic [TOT-1:0]   req,
  input  wire logic [TOT_W-1:0] start,
  output vca_gnt_t              gnt,
  output logic      [TOT_W-1:0] gnt_idx
);

  logic             hi_found;
  logic             lo_found;
  logic [TOT_W-1:0] hi_idx;
  logic [TOT_W-1:0] lo_idx;

  always_comb begin
    hi_found = 1'b0;
    lo_found = 1'b0;
    hi_idx   = '0;
    lo_idx   = '0;
    for (int j = 0; j < TOT; j++) begin
      if (req[j] && !lo_found) begin
        lo_found = 1'b1;
        lo_idx   = TOT_W'(j);
      end
      if (req[j] && !hi_found && (TOT_W'(j) >= start)) begin
        hi_found = 1'b1;
        hi_idx   = TOT_W'(j);
      end
    end
    gnt_idx = hi_found ? hi_idx : lo_idx;
  end

  always_comb begin
    gnt.vld     = hi_found | lo_found;
    gnt.in_port = '0;
    gnt.in_vc   = '0;
    for (int j = 0; j < TOT; j++) begin
      if (TOT_W'(j) == gnt_idx) begin
        gnt.in_port = PORT_FW'(j / NUM_VCS);
        gnt.in_vc   = VC_FW'(j % NUM_VCS);
      end
    end
  end

endmodule

`default_nettype wire
